[design/blgmp_pkg.sv]
// Shared types, constants and helpers for the binary label gap merge and prune block.
package blgmp_pkg;

	// Width of the limit registers and of all run counters (runs never exceed 32).
	localparam int CFG_W       = 6;
	localparam int CNT_W       = 6;
	localparam int RESET_LIMIT = 20;

	// Command queue between the fill front and the prune back.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	typedef enum logic {
		REG_MIN_GAP = 1'b0,
		REG_MIN_SEG = 1'b1
	} cfg_reg_t;

	// A run of count equal samples handed to the prune stage.
	typedef struct packed {
		logic             val;
		logic [CNT_W-1:0] count;
		logic             last;
	} cmd_t;

	// Limit used by a stage: register value held to 1..max_lim.
	function automatic logic [CNT_W-1:0] clamp_limit(input logic [CFG_W-1:0] r,
		input logic [CNT_W-1:0] max_lim);
		logic [CNT_W-1:0] lim;
		if (r == '0)
			lim = CNT_W'(1);
		else if (CNT_W'(r) > max_lim)
			lim = max_lim;
		else
			lim = CNT_W'(r);
		return lim;
	endfunction

endpackage

[design/blgmp_front.sv]
// Gap fill front: turns input labels into run commands for the prune back.
module blgmp_front #(
	parameter int MAX_RUN_LIMIT = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic                        label,
	input  logic                        last,
	input  logic [blgmp_pkg::CFG_W-1:0] min_gap,
	output logic                        push,
	output blgmp_pkg::cmd_t             push_cmd,
	input  logic                        q_full
);

	localparam logic [blgmp_pkg::CNT_W-1:0] MAX_LIM = blgmp_pkg::CNT_W'(MAX_RUN_LIMIT);

	logic [blgmp_pkg::CNT_W-1:0] gap_pend_q;
	logic                        gap_rel_q;
	logic                        hold_v_q;
	blgmp_pkg::cmd_t             hold_q;

	logic [blgmp_pkg::CNT_W-1:0] lim;
	logic [blgmp_pkg::CNT_W-1:0] p;
	logic                        accept;
	logic                        a_v;
	logic                        b_v;
	blgmp_pkg::cmd_t             cmd_a;
	blgmp_pkg::cmd_t             cmd_b;
	logic [blgmp_pkg::CNT_W-1:0] pend_d;
	logic                        rel_d;

	assign item_stall = hold_v_q | q_full;
	assign accept     = item_valid & ~item_stall;
	assign lim        = blgmp_pkg::clamp_limit(min_gap, MAX_LIM);
	assign p          = gap_pend_q + blgmp_pkg::CNT_W'(1);

	always_comb begin
		a_v    = 1'b0;
		b_v    = 1'b0;
		cmd_a  = '{val: 1'b0, count: blgmp_pkg::CNT_W'(1), last: last};
		cmd_b  = '{val: 1'b1, count: blgmp_pkg::CNT_W'(1), last: last};
		pend_d = gap_pend_q;
		rel_d  = gap_rel_q;
		if (!label) begin
			if (gap_rel_q) begin
				a_v = 1'b1;
			end else if (p >= lim || last) begin
				// run reaches the limit, or is flushed at the end: released as lows
				a_v         = 1'b1;
				cmd_a.count = p;
				pend_d      = '0;
				rel_d       = (p >= lim) & ~last;
			end else begin
				pend_d = p;
			end
		end else begin
			if (!gap_rel_q && gap_pend_q != '0) begin
				// held low run ends early: filled high unless it already reached the limit
				a_v         = 1'b1;
				b_v         = 1'b1;
				cmd_a.val   = (gap_pend_q < lim);
				cmd_a.count = gap_pend_q;
				cmd_a.last  = 1'b0;
			end else begin
				a_v       = 1'b1;
				cmd_a.val = 1'b1;
			end
			pend_d = '0;
			rel_d  = 1'b0;
		end
		if (last) begin
			pend_d = '0;
			rel_d  = 1'b0;
		end
	end

	always_comb begin
		if (hold_v_q) begin
			push     = ~q_full;
			push_cmd = hold_q;
		end else begin
			push     = accept & a_v;
			push_cmd = cmd_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_pend_q <= '0;
			gap_rel_q  <= 1'b0;
			hold_v_q   <= 1'b0;
		end else begin
			if (accept) begin
				gap_pend_q <= pend_d;
				gap_rel_q  <= rel_d;
				hold_v_q   <= b_v;
			end else if (hold_v_q && !q_full) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && b_v) begin
			hold_q <= cmd_b;
		end
	end

endmodule

[design/blgmp_fifo.sv]
// Short command queue between the fill front and the prune back.
module blgmp_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  blgmp_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output blgmp_pkg::cmd_t pop_cmd,
	output logic            empty
);

	blgmp_pkg::cmd_t                mem_q [blgmp_pkg::FIFO_DEPTH];
	logic [blgmp_pkg::FIFO_AW:0]    wptr_q;
	logic [blgmp_pkg::FIFO_AW:0]    rptr_q;

	assign empty   = (wptr_q == rptr_q);
	assign full    = (wptr_q[blgmp_pkg::FIFO_AW-1:0] == rptr_q[blgmp_pkg::FIFO_AW-1:0]) &&
	                 (wptr_q[blgmp_pkg::FIFO_AW] != rptr_q[blgmp_pkg::FIFO_AW]);
	assign pop_cmd = mem_q[rptr_q[blgmp_pkg::FIFO_AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (push && !full)
				wptr_q <= wptr_q + {{blgmp_pkg::FIFO_AW{1'b0}}, 1'b1};
			if (pop && !empty)
				rptr_q <= rptr_q + {{blgmp_pkg::FIFO_AW{1'b0}}, 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wptr_q[blgmp_pkg::FIFO_AW-1:0]] <= push_cmd;
		end
	end

endmodule

[design/blgmp_back.sv]
// Prune back: expands run commands sample by sample and releases cleaned results.
module blgmp_back #(
	parameter int MAX_RUN_LIMIT = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [blgmp_pkg::CFG_W-1:0] min_seg,
	input  logic                        q_empty,
	input  blgmp_pkg::cmd_t             q_cmd,
	output logic                        pop,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        clean_label,
	output logic                        last_out
);

	localparam logic [blgmp_pkg::CNT_W-1:0] MAX_LIM = blgmp_pkg::CNT_W'(MAX_RUN_LIMIT);

	// current command
	logic                        cmd_v_q;
	logic                        cmd_val_q;
	logic [blgmp_pkg::CNT_W-1:0] cmd_rem_q;
	logic                        cmd_last_q;
	// prune run state
	logic [blgmp_pkg::CNT_W-1:0] seg_pend_q;
	logic                        seg_rel_q;
	// release in progress: emit_cnt copies of emit_val, then an optional single low
	logic                        emit_val_q;
	logic [blgmp_pkg::CNT_W-1:0] emit_cnt_q;
	logic                        emit_zero_q;
	logic                        emit_last_q;
	// output register
	logic                        res_valid_q;
	logic                        res_label_q;
	logic                        res_last_q;

	logic                        emit_busy;
	logic                        slot;
	logic                        do_emit;
	logic                        do_sample;
	logic                        final_smp;
	logic [blgmp_pkg::CNT_W-1:0] lim;
	logic [blgmp_pkg::CNT_W-1:0] p;
	logic                        a_val;
	logic [blgmp_pkg::CNT_W-1:0] a_cnt;
	logic                        b_zero;
	logic [blgmp_pkg::CNT_W-1:0] pend_d;
	logic                        rel_d;
	logic                        out_label;
	logic                        out_last;

	assign emit_busy = (emit_cnt_q != '0) | emit_zero_q;
	assign slot      = ~res_valid_q | ~result_stall;
	assign do_emit   = emit_busy & slot;
	assign do_sample = ~emit_busy & cmd_v_q;
	assign pop       = ~emit_busy & ~cmd_v_q & ~q_empty;
	assign final_smp = cmd_last_q & (cmd_rem_q == blgmp_pkg::CNT_W'(1));
	assign lim       = blgmp_pkg::clamp_limit(min_seg, MAX_LIM);
	assign p         = seg_pend_q + blgmp_pkg::CNT_W'(1);

	always_comb begin
		a_val  = 1'b1;
		a_cnt  = '0;
		b_zero = 1'b0;
		pend_d = seg_pend_q;
		rel_d  = seg_rel_q;
		if (cmd_val_q) begin
			if (seg_rel_q) begin
				a_cnt = blgmp_pkg::CNT_W'(1);
			end else if (p >= lim || final_smp) begin
				a_cnt  = p;
				pend_d = '0;
				rel_d  = (p >= lim) & ~final_smp;
			end else begin
				pend_d = p;
			end
		end else begin
			if (!seg_rel_q && seg_pend_q != '0) begin
				// short high run cleared unless it already reached the limit
				a_val = ~(seg_pend_q < lim);
				a_cnt = seg_pend_q;
			end
			b_zero = 1'b1;
			pend_d = '0;
			rel_d  = 1'b0;
		end
		if (final_smp) begin
			pend_d = '0;
			rel_d  = 1'b0;
		end
	end

	always_comb begin
		if (emit_cnt_q != '0) begin
			out_label = emit_val_q;
			out_last  = emit_last_q & ~emit_zero_q & (emit_cnt_q == blgmp_pkg::CNT_W'(1));
		end else begin
			out_label = 1'b0;
			out_last  = emit_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_v_q     <= 1'b0;
			cmd_rem_q   <= '0;
			cmd_last_q  <= 1'b0;
			seg_pend_q  <= '0;
			seg_rel_q   <= 1'b0;
			emit_cnt_q  <= '0;
			emit_zero_q <= 1'b0;
			emit_last_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cmd_v_q    <= 1'b1;
				cmd_rem_q  <= q_cmd.count;
				cmd_last_q <= q_cmd.last;
			end else if (do_sample) begin
				cmd_rem_q   <= cmd_rem_q - blgmp_pkg::CNT_W'(1);
				cmd_v_q     <= (cmd_rem_q != blgmp_pkg::CNT_W'(1));
				seg_pend_q  <= pend_d;
				seg_rel_q   <= rel_d;
				emit_cnt_q  <= a_cnt;
				emit_zero_q <= b_zero;
				emit_last_q <= final_smp;
			end else if (do_emit) begin
				if (emit_cnt_q != '0)
					emit_cnt_q <= emit_cnt_q - blgmp_pkg::CNT_W'(1);
				else
					emit_zero_q <= 1'b0;
			end

			if (do_emit)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cmd_val_q <= q_cmd.val;
		if (do_sample)
			emit_val_q <= a_val;
		if (do_emit) begin
			res_label_q <= out_label;
			res_last_q  <= out_last;
		end
	end

	assign result_valid = res_valid_q;
	assign clean_label  = res_label_q;
	assign last_out     = res_last_q;

endmodule

[design/binary_label_gap_merge_prune.sv]
// Top level of the binary label gap merge and prune block: limit registers, front, queue, back.
//
//   channel   signals                                      transfer when
//   item      item_valid, item_stall, label, last          item_valid & !item_stall
//   result    result_valid, result_stall, clean_label,     result_valid & !result_stall
//             last_out
//   cfg       cfg_we, cfg_index, cfg_data                  cfg_we
//
// The front takes one item a cycle while the queue is not full; when a held low run is released
// ahead of a high, it pushes the high from a hold register and stalls the input meanwhile.
// The back loads each run command, steps through it sample by sample, and releases the results
// of each sample one by one. A four-entry command queue lets front and back stall apart; the
// result register holds a result under result_stall while the back loads and samples until it
// has results to release. Reset clears all run state and sets both limits to 20.
module binary_label_gap_merge_prune #(
	parameter int MAX_RUN_LIMIT = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic                        label,
	input  logic                        last,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        clean_label,
	output logic                        last_out,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [blgmp_pkg::CFG_W-1:0] cfg_data
);

	logic [blgmp_pkg::CFG_W-1:0] min_gap_q;
	logic [blgmp_pkg::CFG_W-1:0] min_seg_q;

	logic            push;
	blgmp_pkg::cmd_t push_cmd;
	logic            q_full;
	logic            q_empty;
	logic            pop;
	blgmp_pkg::cmd_t pop_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q <= blgmp_pkg::CFG_W'(blgmp_pkg::RESET_LIMIT);
			min_seg_q <= blgmp_pkg::CFG_W'(blgmp_pkg::RESET_LIMIT);
		end else if (cfg_we) begin
			unique case (blgmp_pkg::cfg_reg_t'(cfg_index))
				blgmp_pkg::REG_MIN_GAP: min_gap_q <= cfg_data;
				blgmp_pkg::REG_MIN_SEG: min_seg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	blgmp_front #(
		.MAX_RUN_LIMIT(MAX_RUN_LIMIT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.label      (label),
		.last       (last),
		.min_gap    (min_gap_q),
		.push       (push),
		.push_cmd   (push_cmd),
		.q_full     (q_full)
	);

	blgmp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	blgmp_back #(
		.MAX_RUN_LIMIT(MAX_RUN_LIMIT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.min_seg      (min_seg_q),
		.q_empty      (q_empty),
		.q_cmd        (pop_cmd),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.clean_label  (clean_label),
		.last_out     (last_out)
	);

endmodule
